### rtl/core/implicit_list_heap_allocator_unit_defines.svh
// Assertion macros shared by the heap allocator modules.
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_UNIT_DEFINES_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled in reset.
`define ILHA_ASSERT_NOW(lbl, cond, chk) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (chk)) \
    else $error("ilha: assertion failed");

// Next-cycle implication, sampled on clk_i, disabled in reset.
`define ILHA_ASSERT_NEXT(lbl, cond, chk) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (chk)) \
    else $error("ilha: assertion failed");

`endif

### rtl/core/ilha_pkg.sv
// Shared types and constants of the heap allocator.
package ilha_pkg;

  localparam int HEAP_BYTES_DEF = 65536;
  localparam int GROW_CHUNK_DEF = 4096;

  localparam int OFF_W = 18;
  localparam int LIM_W = 17;
  localparam int REQ_W = 16;
  localparam int ST_W  = 2;

  localparam logic [LIM_W-1:0] LIM_RST     = 17'h10000;
  localparam logic [OFF_W-1:0] BRK_RST     = 18'd4112;
  localparam logic [OFF_W-1:0] PROLOGUE_BP = 18'd8;
  localparam logic [OFF_W-1:0] FIRST_BP    = 18'd16;
  localparam logic [OFF_W-1:0] MIN_BLOCK   = 18'd16;

  typedef enum logic [ST_W-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_ZERO  = 2'd1,
    STATUS_NOMEM = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_CLR, OP_LATCH, OP_DISPATCH, OP_RD_HDR, OP_ADV, OP_CHK, OP_BP8,
    OP_PL_W0, OP_PL_W1, OP_PL_W2, OP_PL_W3, OP_GROW_CALC, OP_FAIL,
    OP_G_W0, OP_G_W1, OP_G_W2, OP_MG1, OP_MG2, OP_MG3, OP_M_W0, OP_M_W1,
    OP_MG_END, OP_F_W0, OP_F_W1, OP_OUT_LOAD
  } dp_op_e;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_DISPATCH,
    S_S1_RD0, S_S1_ADV, S_S1_RD, S_S1_CHK,
    S_S2_INIT, S_S2_CHK, S_S2_RDS, S_S2_S, S_S2_RDH, S_S2_H,
    S_PL_W0, S_PL_W1, S_PL_W2, S_PL_W3,
    S_GROW, S_GROW_CHK, S_G_W0, S_G_W1, S_G_W2,
    S_M_RD0, S_M_RD1, S_M_RD2, S_M_CMB, S_M_W0, S_M_W1, S_M_END,
    S_V_RD, S_V_CHK, S_V_ADV, S_F_W0, S_F_W1,
    S_FIN
  } ctl_state_e;

  typedef struct packed {
    logic is_free;
    logic rel_zero;
    logic req_zero;
    logic h_zero;
    logic h_alloc;
    logic h_fit;
    logic n_max;
    logic bp_ge_lfb;
    logic bp_gt_rel;
    logic bp_eq_rel;
    logic no_room;
    logic split;
    logic mg_tag;
    logic clr_last;
  } dp_flags_t;

endpackage

### rtl/core/ilha_if.sv
// Channel interfaces: request, response and limit write.
interface ilha_req_if import ilha_pkg::*;;
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [REQ_W-1:0] request_bytes;
  logic [REQ_W-1:0] release_offset;
  modport source(output valid, opcode, request_bytes, release_offset, input ready);
  modport sink(input valid, opcode, request_bytes, release_offset, output ready);
endinterface

interface ilha_rsp_if import ilha_pkg::*;;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] block_offset;
  logic [ST_W-1:0]  status;
  modport source(output valid, block_offset, status, input ready);
  modport sink(input valid, block_offset, status, output ready);
endinterface

interface ilha_cfg_if import ilha_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] heap_limit_bytes;
  modport source(output valid, heap_limit_bytes, input ready);
  modport sink(input valid, heap_limit_bytes, output ready);
endinterface

### rtl/core/implicit_list_heap_allocator_unit.sv
// Top level of the implicit-list next-fit heap allocator.
// The heap image lives in one single-port memory of HEAP_BYTES/4 words, and every
// memory access of an item, read or write, goes through that one port. After reset
// the block first sweeps the memory once to lay down the prologue, the initial
// 4096-byte free block and the epilogue, during which no request is taken; limit
// writes are taken at any time. An allocate walks the block headers from the last
// placed block on, then wraps to the heap start, and grows the heap when no block
// fits; a free walks from the heap start to the freed block and then merges it.
// One request is in work at a time; its result waits in an output register.
module implicit_list_heap_allocator_unit import ilha_pkg::*; #(
  parameter int HEAP_BYTES       = HEAP_BYTES_DEF,
  parameter int GROW_CHUNK_BYTES = GROW_CHUNK_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilha_req_if.sink   req_i,
  ilha_rsp_if.source rsp_o,
  ilha_cfg_if.sink   cfg_i
);

  dp_flags_t flags;
  dp_op_e    op;

  assign cfg_i.ready = 1'b1;

  ilha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .flags_i     (flags),
    .op_o        (op)
  );

  ilha_dp #(
    .HEAP_BYTES       (HEAP_BYTES),
    .GROW_CHUNK_BYTES (GROW_CHUNK_BYTES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.heap_limit_bytes),
    .opcode_i         (req_i.opcode),
    .request_bytes_i  (req_i.request_bytes),
    .release_offset_i (req_i.release_offset),
    .flags_o          (flags),
    .block_offset_o   (rsp_o.block_offset),
    .status_o         (rsp_o.status)
  );

endmodule

### rtl/core/ilha_dp.sv
// Datapath of the heap allocator: heap memory, pointers and size arithmetic.
`include "implicit_list_heap_allocator_unit_defines.svh"
module ilha_dp import ilha_pkg::*; #(
  parameter int HEAP_BYTES       = HEAP_BYTES_DEF,
  parameter int GROW_CHUNK_BYTES = GROW_CHUNK_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dp_op_e           op_i,
  input  logic             cfg_we_i,
  input  logic [LIM_W-1:0] cfg_data_i,
  input  logic             opcode_i,
  input  logic [REQ_W-1:0] request_bytes_i,
  input  logic [REQ_W-1:0] release_offset_i,
  output dp_flags_t        flags_o,
  output logic [REQ_W-1:0] block_offset_o,
  output logic [ST_W-1:0]  status_o
);

  localparam int NWORDS = HEAP_BYTES / 4;
  localparam int AW     = $clog2(NWORDS);
  localparam int CW     = $clog2(NWORDS + 1);
  localparam logic [OFF_W-1:0] LIM_CAP =
    (HEAP_BYTES < 65536) ? OFF_W'(HEAP_BYTES) : OFF_W'(65536);
  localparam logic [OFF_W-1:0] CHUNK = OFF_W'(GROW_CHUNK_BYTES);

  function automatic logic [31:0] tag_word(input logic [OFF_W-1:0] sz, input logic a);
    tag_word = {{(32-OFF_W){1'b0}}, sz} | {31'b0, a};
  endfunction

  function automatic logic [31:0] init_word(input logic [AW-1:0] a);
    logic [31:0] w;
    w = 32'd0;
    if (a == AW'(1) || a == AW'(2)) w = 32'd9;
    if (a == AW'(3) || a == AW'(1026)) w = 32'd4096;
    if (a == AW'(1027)) w = 32'd1;
    init_word = w;
  endfunction

  logic [31:0]      mem_q [NWORDS];
  logic [31:0]      rdata_q;
  logic             rd_oob_q;

  logic [LIM_W-1:0] lim_q, lim_d;
  logic [OFF_W-1:0] brk_q, brk_d;
  logic [OFF_W-1:0] lfb_q, lfb_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic [OFF_W-1:0] bp_q, bp_d;
  logic [OFF_W-1:0] asz_q, asz_d;
  logic [OFF_W-1:0] csz_q, csz_d;
  logic [OFF_W-1:0] sz_q, sz_d;
  logic [OFF_W-1:0] psz_q, psz_d;
  logic             pa_q, pa_d;
  logic [REQ_W-1:0] res_q, res_d;
  status_e          st_q, st_d;
  logic             opc_q, opc_d;
  logic [REQ_W-1:0] req_q, req_d;
  logic [REQ_W-1:0] rel_q, rel_d;
  logic [REQ_W-1:0] out_off_q, out_off_d;
  status_e          out_st_q, out_st_d;

  logic [31:0]      rdw;
  logic [OFF_W-1:0] hsz;
  logic [OFF_W-1:0] asz;
  logic [OFF_W-1:0] ext;
  logic [15:0]      gw;
  logic [OFF_W-1:0] gsz;
  logic [OFF_W-1:0] lim_eff;
  logic             split;
  logic [OFF_W-1:0] rem;
  logic [OFF_W-1:0] off;
  logic [15:0]      idx;
  logic             in_rng;
  logic             mem_re;
  logic             mem_we;
  logic             wr_req;
  logic [AW-1:0]    mem_addr;
  logic [31:0]      wdata;

  assign rdw   = rd_oob_q ? 32'd0 : rdata_q;
  assign hsz   = {rdw[OFF_W-1:3], 3'b000};
  assign asz   = (req_q <= REQ_W'(8)) ? MIN_BLOCK
               : (({2'b00, req_q} + OFF_W'(15)) & ~OFF_W'(7));
  assign ext   = (asz_q > CHUNK) ? asz_q : CHUNK;
  assign gw    = ext[OFF_W-1:2] + {15'b0, ext[2]};
  assign gsz   = {gw, 2'b00};
  assign lim_eff = ({1'b0, lim_q} > LIM_CAP) ? LIM_CAP : {1'b0, lim_q};
  assign split = csz_q >= asz_q + MIN_BLOCK;
  assign rem   = csz_q - asz_q;

  assign idx    = off[OFF_W-1:2];
  assign in_rng = int'(idx) < NWORDS;

  always_comb begin
    off    = bp_q - OFF_W'(4);
    mem_re = 1'b0;
    wr_req = 1'b0;
    wdata  = 32'd0;
    lim_d  = cfg_we_i ? cfg_data_i : lim_q;
    brk_d  = brk_q;
    lfb_d  = lfb_q;
    cnt_d  = cnt_q;
    bp_d   = bp_q;
    asz_d  = asz_q;
    csz_d  = csz_q;
    sz_d   = sz_q;
    psz_d  = psz_q;
    pa_d   = pa_q;
    res_d  = res_q;
    st_d   = st_q;
    opc_d  = opc_q;
    req_d  = req_q;
    rel_d  = rel_q;
    out_off_d = out_off_q;
    out_st_d  = out_st_q;
    unique case (op_i)
      OP_NOP: begin
      end
      OP_CLR: begin
        wr_req = 1'b1;
        wdata  = init_word(cnt_q[AW-1:0]);
        cnt_d  = cnt_q + CW'(1);
      end
      OP_LATCH: begin
        opc_d = opcode_i;
        req_d = request_bytes_i;
        rel_d = release_offset_i;
      end
      OP_DISPATCH: begin
        res_d = '0;
        st_d  = (!opc_q && req_q == '0) ? STATUS_ZERO : STATUS_DONE;
        bp_d  = opc_q ? FIRST_BP : lfb_q;
        cnt_d = '0;
        asz_d = asz;
      end
      OP_RD_HDR: begin
        mem_re = 1'b1;
      end
      OP_ADV: begin
        bp_d = bp_q + hsz;
      end
      OP_CHK: begin
        csz_d = hsz;
        cnt_d = cnt_q + CW'(1);
      end
      OP_BP8: begin
        bp_d  = PROLOGUE_BP;
        cnt_d = '0;
      end
      OP_PL_W0: begin
        wr_req = 1'b1;
        wdata  = split ? tag_word(asz_q, 1'b1) : tag_word(csz_q, 1'b1);
        lfb_d  = bp_q;
        res_d  = bp_q[REQ_W-1:0];
      end
      OP_PL_W1: begin
        wr_req = 1'b1;
        off    = split ? (bp_q + asz_q - OFF_W'(8)) : (bp_q + csz_q - OFF_W'(8));
        wdata  = split ? tag_word(asz_q, 1'b1) : tag_word(csz_q, 1'b1);
      end
      OP_PL_W2: begin
        wr_req = 1'b1;
        off    = bp_q + asz_q - OFF_W'(4);
        wdata  = tag_word(rem, 1'b0);
      end
      OP_PL_W3: begin
        wr_req = 1'b1;
        off    = bp_q + csz_q - OFF_W'(8);
        wdata  = tag_word(rem, 1'b0);
      end
      OP_GROW_CALC: begin
        sz_d = gsz;
      end
      OP_FAIL: begin
        st_d = STATUS_NOMEM;
      end
      OP_G_W0: begin
        wr_req = 1'b1;
        off    = brk_q - OFF_W'(4);
        wdata  = tag_word(sz_q, 1'b0);
        bp_d   = brk_q;
      end
      OP_G_W1: begin
        wr_req = 1'b1;
        off    = bp_q + sz_q - OFF_W'(8);
        wdata  = tag_word(sz_q, 1'b0);
      end
      OP_G_W2: begin
        wr_req = 1'b1;
        off    = bp_q + sz_q - OFF_W'(4);
        wdata  = 32'd1;
        brk_d  = brk_q + sz_q;
      end
      OP_MG1: begin
        mem_re = 1'b1;
        off    = bp_q - OFF_W'(8);
        sz_d   = hsz;
      end
      OP_MG2: begin
        mem_re = 1'b1;
        off    = bp_q + sz_q - OFF_W'(4);
        pa_d   = rdw[0];
        psz_d  = hsz;
      end
      OP_MG3: begin
        bp_d = pa_q ? bp_q : (bp_q - psz_q);
        sz_d = sz_q + (pa_q ? '0 : psz_q) + (rdw[0] ? '0 : hsz);
      end
      OP_M_W0: begin
        wr_req = 1'b1;
        wdata  = tag_word(sz_q, 1'b0);
      end
      OP_M_W1: begin
        wr_req = 1'b1;
        off    = bp_q + sz_q - OFF_W'(8);
        wdata  = tag_word(sz_q, 1'b0);
      end
      OP_MG_END: begin
        lfb_d = bp_q;
        csz_d = sz_q;
      end
      OP_F_W0: begin
        wr_req = 1'b1;
        wdata  = tag_word(csz_q, 1'b0);
      end
      OP_F_W1: begin
        wr_req = 1'b1;
        off    = bp_q + csz_q - OFF_W'(8);
        wdata  = tag_word(csz_q, 1'b0);
      end
      OP_OUT_LOAD: begin
        out_off_d = res_q;
        out_st_d  = st_q;
      end
      default: begin
      end
    endcase
  end

  assign mem_we   = wr_req && ((op_i == OP_CLR) || in_rng);
  assign mem_addr = (op_i == OP_CLR) ? cnt_q[AW-1:0] : AW'(idx);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wdata;
    end
    if (mem_re) begin
      rdata_q  <= mem_q[mem_addr];
      rd_oob_q <= !in_rng;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIM_RST;
      brk_q <= BRK_RST;
      lfb_q <= PROLOGUE_BP;
      cnt_q <= '0;
    end else begin
      lim_q <= lim_d;
      brk_q <= brk_d;
      lfb_q <= lfb_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bp_q      <= bp_d;
    asz_q     <= asz_d;
    csz_q     <= csz_d;
    sz_q      <= sz_d;
    psz_q     <= psz_d;
    pa_q      <= pa_d;
    res_q     <= res_d;
    st_q      <= st_d;
    opc_q     <= opc_d;
    req_q     <= req_d;
    rel_q     <= rel_d;
    out_off_q <= out_off_d;
    out_st_q  <= out_st_d;
  end

  always_comb begin
    flags_o.is_free   = opc_q;
    flags_o.rel_zero  = rel_q == '0;
    flags_o.req_zero  = req_q == '0;
    flags_o.h_zero    = hsz == '0;
    flags_o.h_alloc   = rdw[0];
    flags_o.h_fit     = hsz >= asz_q;
    flags_o.n_max     = cnt_q >= CW'(NWORDS);
    flags_o.bp_ge_lfb = bp_q >= lfb_q;
    flags_o.bp_gt_rel = bp_q > {2'b00, rel_q};
    flags_o.bp_eq_rel = bp_q == {2'b00, rel_q};
    flags_o.no_room   = (brk_q + sz_q > lim_eff) || (brk_q > lim_eff);
    flags_o.split     = split;
    flags_o.mg_tag    = !pa_q || !rdw[0];
    flags_o.clr_last  = cnt_q == CW'(NWORDS - 1);
  end

  assign block_offset_o = out_off_q;
  assign status_o       = out_st_q;

  `ILHA_ASSERT_NOW(a_rw_excl, mem_re, !wr_req)
  `ILHA_ASSERT_NOW(a_brk_align, 1'b1, brk_q[2:0] == 3'b000)
  `ILHA_ASSERT_NOW(a_lfb_align, 1'b1, lfb_q[2:0] == 3'b000)

endmodule

### rtl/core/ilha_ctrl.sv
// Controller of the heap allocator: sequences search, placement, growth and merge.
`include "implicit_list_heap_allocator_unit_defines.svh"
module ilha_ctrl import ilha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  dp_flags_t flags_i,
  output dp_op_e    op_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  logic       fit;

  assign out_free = !out_valid_q || rsp_ready_i;
  assign fit      = !flags_i.h_alloc && flags_i.h_fit;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLR:      if (flags_i.clr_last) state_d = S_IDLE;
      S_IDLE:     if (req_valid_i) state_d = S_DISPATCH;
      S_DISPATCH: begin
        if (flags_i.is_free) begin
          state_d = flags_i.rel_zero ? S_FIN : S_V_RD;
        end else begin
          state_d = flags_i.req_zero ? S_FIN : S_S1_RD0;
        end
      end
      S_S1_RD0:   state_d = S_S1_ADV;
      S_S1_ADV:   state_d = S_S1_RD;
      S_S1_RD:    state_d = S_S1_CHK;
      S_S1_CHK: begin
        priority if (flags_i.n_max || flags_i.h_zero) state_d = S_S2_INIT;
        else if (fit) state_d = S_PL_W0;
        else state_d = S_S1_ADV;
      end
      S_S2_INIT:  state_d = S_S2_CHK;
      S_S2_CHK:   state_d = (flags_i.n_max || flags_i.bp_ge_lfb) ? S_GROW : S_S2_RDS;
      S_S2_RDS:   state_d = S_S2_S;
      S_S2_S:     state_d = flags_i.h_zero ? S_GROW : S_S2_RDH;
      S_S2_RDH:   state_d = S_S2_H;
      S_S2_H:     state_d = fit ? S_PL_W0 : S_S2_CHK;
      S_PL_W0:    state_d = S_PL_W1;
      S_PL_W1:    state_d = flags_i.split ? S_PL_W2 : S_FIN;
      S_PL_W2:    state_d = S_PL_W3;
      S_PL_W3:    state_d = S_FIN;
      S_GROW:     state_d = S_GROW_CHK;
      S_GROW_CHK: state_d = flags_i.no_room ? S_FIN : S_G_W0;
      S_G_W0:     state_d = S_G_W1;
      S_G_W1:     state_d = S_G_W2;
      S_G_W2:     state_d = S_M_RD0;
      S_M_RD0:    state_d = S_M_RD1;
      S_M_RD1:    state_d = S_M_RD2;
      S_M_RD2:    state_d = S_M_CMB;
      S_M_CMB:    state_d = flags_i.mg_tag ? S_M_W0 : S_M_END;
      S_M_W0:     state_d = S_M_W1;
      S_M_W1:     state_d = S_M_END;
      S_M_END:    state_d = flags_i.is_free ? S_FIN : S_PL_W0;
      S_V_RD:     state_d = S_V_CHK;
      S_V_CHK: begin
        priority if (flags_i.n_max || flags_i.h_zero || flags_i.bp_gt_rel) state_d = S_FIN;
        else if (flags_i.bp_eq_rel) state_d = flags_i.h_alloc ? S_F_W0 : S_FIN;
        else state_d = S_V_ADV;
      end
      S_V_ADV:    state_d = S_V_RD;
      S_F_W0:     state_d = S_F_W1;
      S_F_W1:     state_d = S_M_RD0;
      S_FIN:      if (out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    op_o = OP_NOP;
    unique case (state_q)
      S_CLR:      op_o = OP_CLR;
      S_IDLE:     op_o = req_valid_i ? OP_LATCH : OP_NOP;
      S_DISPATCH: op_o = OP_DISPATCH;
      S_S1_RD0, S_S1_RD, S_S2_RDS, S_S2_RDH, S_V_RD, S_M_RD0: op_o = OP_RD_HDR;
      S_S1_ADV, S_S2_S, S_V_ADV: op_o = OP_ADV;
      S_S1_CHK, S_S2_H, S_V_CHK: op_o = OP_CHK;
      S_S2_INIT:  op_o = OP_BP8;
      S_S2_CHK:   op_o = OP_NOP;
      S_PL_W0:    op_o = OP_PL_W0;
      S_PL_W1:    op_o = OP_PL_W1;
      S_PL_W2:    op_o = OP_PL_W2;
      S_PL_W3:    op_o = OP_PL_W3;
      S_GROW:     op_o = OP_GROW_CALC;
      S_GROW_CHK: op_o = flags_i.no_room ? OP_FAIL : OP_NOP;
      S_G_W0:     op_o = OP_G_W0;
      S_G_W1:     op_o = OP_G_W1;
      S_G_W2:     op_o = OP_G_W2;
      S_M_RD1:    op_o = OP_MG1;
      S_M_RD2:    op_o = OP_MG2;
      S_M_CMB:    op_o = OP_MG3;
      S_M_W0:     op_o = OP_M_W0;
      S_M_W1:     op_o = OP_M_W1;
      S_M_END:    op_o = OP_MG_END;
      S_F_W0:     op_o = OP_F_W0;
      S_F_W1:     op_o = OP_F_W1;
      S_FIN:      op_o = out_free ? OP_OUT_LOAD : OP_NOP;
      default:    op_o = OP_NOP;
    endcase
  end

  assign out_valid_d = (out_valid_q && !rsp_ready_i) || (state_q == S_FIN && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = state_q == S_IDLE;
  assign rsp_valid_o = out_valid_q;

  `ILHA_ASSERT_NEXT(a_accept_dispatch, state_q == S_IDLE && req_valid_i, state_q == S_DISPATCH)
  `ILHA_ASSERT_NEXT(a_fin_delivers, state_q == S_FIN && out_free, out_valid_q && state_q == S_IDLE)
  `ILHA_ASSERT_NOW(a_clr_quiet, state_q == S_CLR, !out_valid_q)

endmodule
